// File: rtl/bks_pkg.sv
// Shared types, constants and state codes for the binned KS distance block.
// No dependencies; bks_job_fifo, bks_front, bks_back and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package bks_pkg;

	// Field widths fixed by the data format
	localparam int W_WEIGHT  = 16;   // unsigned Q8.8 bin weight
	localparam int W_DIST    = 16;   // Q0.16 result fraction
	localparam int W_STATUS  = 2;

	// Default store depth and depth of the request queue between front and back
	localparam int MAX_BINS_DEFAULT = 64;
	localparam int JOB_QUEUE_DEPTH  = 2;

	// Saturated result for a difference of one or more
	localparam logic [W_DIST-1:0] DIST_SAT = '1;

	// Result status codes
	localparam logic [W_STATUS-1:0] STATUS_OK       = 2'd0;
	localparam logic [W_STATUS-1:0] STATUS_ZERO_SUM = 2'd1;
	localparam logic [W_STATUS-1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [W_WEIGHT-1:0] weight_a;
		logic [W_WEIGHT-1:0] weight_b;
		logic                last_bin;
	} item_t;

	typedef struct packed {
		logic [W_DIST-1:0]   max_distance;
		logic [W_STATUS-1:0] status;
	} result_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_SCAN,
		BK_DRAIN,
		BK_PREP,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/bks_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bks_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/bks_job_fifo.sv
// Short request queue between the loading front end and the scanning back end.
// Uses bks_pkg for its default depth.
`timescale 1ns / 1ps
`default_nettype none

module bks_job_fifo #(
	parameter int WIDTH = 52,
	parameter int DEPTH = bks_pkg::JOB_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	import bks_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop && not_empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push && !full, pop && not_empty})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/bks_front.sv
// Front end: accepts bin pairs, keeps running sums and writes prefix sums to the stores.
// On the last bin it queues a scan request. Uses bks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bks_front #(
	parameter int MAX_BINS = bks_pkg::MAX_BINS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  bks_pkg::item_t                         item,
	// store write port (both stores share address and enable)
	output logic                                   ram_we,
	output logic [$clog2(MAX_BINS)-1:0]            ram_waddr,
	output logic [bks_pkg::W_WEIGHT+$clog2(MAX_BINS)-1:0] ram_wdata_a,
	output logic [bks_pkg::W_WEIGHT+$clog2(MAX_BINS)-1:0] ram_wdata_b,
	// request queue
	output logic                                   job_push,
	output logic [$clog2(MAX_BINS+1)+2*(bks_pkg::W_WEIGHT+$clog2(MAX_BINS)):0] job_data,
	input  logic                                   job_full,
	// store released by the back end
	input  logic                                   scan_done,
	output logic                                   busy
);

	import bks_pkg::*;

	localparam int AW   = $clog2(MAX_BINS);
	localparam int CNTW = $clog2(MAX_BINS + 1);
	localparam int SW   = W_WEIGHT + AW;

	typedef struct packed {
		logic [CNTW-1:0] n;
		logic [SW-1:0]   ta;
		logic [SW-1:0]   tb;
		logic            ovf;
	} job_t;

	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   sum_a_q, sum_b_q;
	logic            ovf_q;
	logic            busy_q;

	logic            accept;
	logic            room;
	logic [SW-1:0]   sum_a_d, sum_b_d;
	logic [CNTW-1:0] cnt_d;
	job_t            job;

	// Hold off while the store is reserved for a pending scan or the request queue is full
	assign item_stall = busy_q || job_full;
	assign accept     = item_valid && !item_stall;
	assign room       = (cnt_q != CNTW'(MAX_BINS));
	assign busy       = busy_q;

	// Next prefix sums; a dropped bin leaves them unchanged
	assign sum_a_d = room ? sum_a_q + SW'(item.weight_a) : sum_a_q;
	assign sum_b_d = room ? sum_b_q + SW'(item.weight_b) : sum_b_q;
	assign cnt_d   = room ? cnt_q + CNTW'(1) : cnt_q;

	assign ram_we      = accept && room;
	assign ram_waddr   = cnt_q[AW-1:0];
	assign ram_wdata_a = sum_a_d;
	assign ram_wdata_b = sum_b_d;

	// Scan request for the completed data set
	always_comb begin
		job.n   = cnt_d;
		job.ta  = sum_a_d;
		job.tb  = sum_b_d;
		job.ovf = ovf_q || !room;
	end
	assign job_push = accept && item.last_bin;
	assign job_data = job;

	// Data set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			ovf_q   <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (item.last_bin) begin
					cnt_q   <= '0;
					sum_a_q <= '0;
					sum_b_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					cnt_q   <= cnt_d;
					sum_a_q <= sum_a_d;
					sum_b_q <= sum_b_d;
					ovf_q   <= ovf_q || !room;
				end
			end
			if (job_push) begin
				busy_q <= 1'b1;
			end else if (scan_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/bks_back.sv
// Back end: scans stored prefix sums for the largest cross-scaled difference,
// then divides by the product of the totals one quotient bit a cycle (or saturates). Uses bks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bks_back #(
	parameter int MAX_BINS = bks_pkg::MAX_BINS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request queue
	input  logic                                   job_valid,
	input  logic [$clog2(MAX_BINS+1)+2*(bks_pkg::W_WEIGHT+$clog2(MAX_BINS)):0] job_data,
	output logic                                   job_pop,
	// store read port
	output logic                                   ram_re,
	output logic [$clog2(MAX_BINS)-1:0]            ram_raddr,
	input  logic [bks_pkg::W_WEIGHT+$clog2(MAX_BINS)-1:0] ram_rdata_a,
	input  logic [bks_pkg::W_WEIGHT+$clog2(MAX_BINS)-1:0] ram_rdata_b,
	output logic                                   scan_done,
	// result channel
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output bks_pkg::result_t                       result
);

	import bks_pkg::*;

	localparam int AW   = $clog2(MAX_BINS);
	localparam int CNTW = $clog2(MAX_BINS + 1);
	localparam int SW   = W_WEIGHT + AW;
	localparam int PW   = 2 * SW;
	localparam int DCW  = $clog2(W_DIST);

	typedef struct packed {
		logic [CNTW-1:0] n;
		logic [SW-1:0]   ta;
		logic [SW-1:0]   tb;
		logic            ovf;
	} job_t;

	back_state_t     state_q, state_d;
	job_t            job;

	logic [CNTW-1:0] n_q, rd_idx_q;
	logic [SW-1:0]   ta_q, tb_q;
	logic            ovf_q, zero_q;
	logic [PW-1:0]   den_q, best_q, rem_q;
	logic [W_DIST-1:0] quo_q;
	logic [DCW-1:0]  div_cnt_q;

	logic            v_s1, v_s2, v_s3;
	logic [PW-1:0]   x_s2, y_s2, d_s3;
	logic [PW-1:0]   prod_x, prod_y;
	logic [PW:0]     rem_sh;

	logic            zero_total;
	logic            out_load;
	logic            res_valid_q;
	result_t         result_q;

	assign job        = job_data;
	assign zero_total = (ta_q == '0) || (tb_q == '0);
	assign ram_raddr  = rd_idx_q[AW-1:0];
	assign out_load   = (state_q == BK_FIN) && (!res_valid_q || !result_stall);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		ram_re    = 1'b0;
		scan_done = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				// zero total: no scan, store released at once
				if (zero_total) begin
					scan_done = 1'b1;
					state_d   = BK_FIN;
				end else begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				ram_re = 1'b1;
				if (rd_idx_q == n_q - CNTW'(1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					scan_done = 1'b1;
					state_d   = BK_PREP;
				end
			end
			BK_PREP: begin
				state_d = (best_q >= den_q) ? BK_FIN : BK_DIV;
			end
			BK_DIV: begin
				if (div_cnt_q == DCW'(W_DIST - 1)) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Request latch, scan index and divider
	assign rem_sh = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					n_q   <= job.n;
					ta_q  <= job.ta;
					tb_q  <= job.tb;
					ovf_q <= job.ovf;
				end
			end
			BK_LOAD: begin
				den_q    <= PW'(ta_q) * PW'(tb_q);
				zero_q   <= zero_total;
				rd_idx_q <= '0;
				quo_q    <= '0;
			end
			BK_SCAN: begin
				rd_idx_q <= rd_idx_q + CNTW'(1);
			end
			BK_PREP: begin
				if (best_q >= den_q) begin
					quo_q <= DIST_SAT;
				end else begin
					rem_q     <= best_q;
					quo_q     <= '0;
					div_cnt_q <= '0;
				end
			end
			BK_DIV: begin
				// restoring step: one quotient bit
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= PW'(rem_sh - {1'b0, den_q});
					quo_q <= {quo_q[W_DIST-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[PW-1:0];
					quo_q <= {quo_q[W_DIST-2:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			default: ;
		endcase
	end

	// Scan pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Cross-scaled terms: ca * TB and cb * TA
	assign prod_x = PW'(ram_rdata_a) * PW'(tb_q);
	assign prod_y = PW'(ram_rdata_b) * PW'(ta_q);

	always_ff @(posedge clk) begin
		x_s2 <= prod_x;
		y_s2 <= prod_y;
		d_s3 <= (x_s2 >= y_s2) ? x_s2 - y_s2 : y_s2 - x_s2;
	end

	// Running maximum, cleared at the start of each scan
	always_ff @(posedge clk) begin
		if (state_q == BK_LOAD) begin
			best_q <= '0;
		end else if (v_s3 && (d_s3 > best_q)) begin
			best_q <= d_s3;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.max_distance <= zero_q ? '0 : quo_q;
			result_q.status       <= ovf_q ? STATUS_OVERFLOW :
			                         (zero_q ? STATUS_ZERO_SUM : STATUS_OK);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: rtl/binned_ks_max_distance_top.sv
// Top level of the binned two-sample KS distance block: front end, request queue,
// prefix-sum stores and back end. Uses bks_pkg, bks_ram, bks_job_fifo, bks_front, bks_back.
//
//  channel   signals                        moves
//  input     item_valid / item_stall / item  one bin pair (weight_a, weight_b, last_bin)
//  output    result_valid / result_stall / result  max_distance and status per data set
//
// Loading takes one bin pair per cycle with no gap between items.
// After the last bin the input stalls until the scan has read the stores, one read a
// cycle; with a zero total there is no scan and the stores are released at once.
// After the scan the result passes the saturation test, a 16-step divide and the output load;
// a saturated difference skips the divide, and a zero total goes straight to the output load.
// Reset clears all control state; the stores need no clearing pass.
// A stalled result holds in its output register while the next data set loads.
`timescale 1ns / 1ps
`default_nettype none

module binned_ks_max_distance_top #(
	parameter int MAX_BINS = bks_pkg::MAX_BINS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bks_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bks_pkg::result_t result
);

	import bks_pkg::*;

	localparam int AW   = $clog2(MAX_BINS);
	localparam int CNTW = $clog2(MAX_BINS + 1);
	localparam int SW   = W_WEIGHT + AW;
	localparam int JW   = CNTW + 2 * SW + 1;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [SW-1:0]   wdata_a, wdata_b, rdata_a, rdata_b;
	logic            job_push, job_full, job_pop, job_valid;
	logic [JW-1:0]   job_in, job_out;
	logic            scan_done, busy;

	bks_front #(.MAX_BINS(MAX_BINS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata_a (wdata_a),
		.ram_wdata_b (wdata_b),
		.job_push    (job_push),
		.job_data    (job_in),
		.job_full    (job_full),
		.scan_done   (scan_done),
		.busy        (busy)
	);

	bks_job_fifo #(.WIDTH(JW), .DEPTH(JOB_QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.pop_data  (job_out)
	);

	bks_ram #(.WIDTH(SW), .DEPTH(MAX_BINS)) u_store_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata_a),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata_a)
	);

	bks_ram #(.WIDTH(SW), .DEPTH(MAX_BINS)) u_store_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata_b),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata_b)
	);

	bks_back #(.MAX_BINS(MAX_BINS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_data     (job_out),
		.job_pop      (job_pop),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata_a  (rdata_a),
		.ram_rdata_b  (rdata_b),
		.scan_done    (scan_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A zero total always reports a zero distance
	a_zero_sum_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == STATUS_ZERO_SUM) |-> result.max_distance == '0)
		else $error("zero-total result with nonzero distance");

	// The store is released only while a data set holds it
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> busy)
		else $error("scan finished with no reserved data set");

	// A closing bin reserves the store for the scan
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.last_bin |=> item_stall)
		else $error("input not held after last bin");

	// Stores are never written while the back end reads them
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !ram_we)
		else $error("store written during scan");

endmodule

`default_nettype wire
